// File: rtl/core/swdg_pkg.sv
// Shared types and constants for the multi-channel soft watchdog.
// No dependencies; every other file of the block imports this package.
package swdg_pkg;

    localparam int OP_W      = 2;
    localparam int CH_W      = 3;
    localparam int TIMEOUT_W = 24;
    localparam int CODE_W    = 8;
    localparam int STEP_W    = 16;
    localparam int KIND_W    = 2;
    localparam int COLOUR_W  = 3;
    localparam int BEEPS_W   = 2;

    // At most this many suspend results come out of one tick.
    localparam int SLOT_LIMIT = 8;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd10;

    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE = 2'd1;
    localparam logic [OP_W-1:0] OP_FEED   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESUME  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUSPEND = 2'd2;

    // Valid alarm codes: colour nibble 1..6, beep nibble 1..2.
    localparam logic [3:0] COLOUR_FIRST = 4'd1;
    localparam logic [3:0] COLOUR_LAST  = 4'd6;
    localparam logic [3:0] BEEPS_FIRST  = 4'd1;
    localparam logic [3:0] BEEPS_LAST   = 4'd2;

    typedef struct packed {
        logic                 valid;
        logic                 alarm;
        logic [TIMEOUT_W-1:0] timeout;
        logic [TIMEOUT_W-1:0] residue;
        logic [CODE_W-1:0]    code;
    } slot_t;

    typedef struct packed {
        logic                 create;
        logic                 feed;
        logic [TIMEOUT_W-1:0] timeout;
        logic [CODE_W-1:0]    code;
    } cell_cmd_t;

endpackage

// File: rtl/core/swdg_if.sv
// Valid/ready channel interfaces for watchdog requests and results.
// Depends on swdg_pkg for the field widths.
interface swdg_req_if import swdg_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      opcode;
    logic [CH_W-1:0]      channel;
    logic [TIMEOUT_W-1:0] timeout;
    logic [CODE_W-1:0]    alarm_code;
    logic                 sound_enable;

    modport source (output valid, opcode, channel, timeout, alarm_code, sound_enable,
                    input ready);
    modport sink   (input valid, opcode, channel, timeout, alarm_code, sound_enable,
                    output ready);
endinterface

interface swdg_rsp_if import swdg_pkg::*;;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CH_W-1:0]     slot;
    logic [COLOUR_W-1:0] colour;
    logic [BEEPS_W-1:0]  beeps;
    logic                last;

    modport source (output valid, kind, slot, colour, beeps, last, input ready);
    modport sink   (input valid, kind, slot, colour, beeps, last, output ready);
endinterface

// File: rtl/core/swdg_cell.sv
// One watchdog slot of the rotating cell chain.
// Depends on swdg_pkg for slot_t and cell_cmd_t.
module swdg_cell import swdg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cmd_t cmd,
    input  logic      sel,
    input  logic      shift_en,
    input  slot_t     shift_in,
    output slot_t     slot_q
);

    logic                 valid_reg, valid_next;
    logic                 alarm_reg, alarm_next;
    logic [TIMEOUT_W-1:0] timeout_reg, timeout_next;
    logic [TIMEOUT_W-1:0] residue_reg, residue_next;
    logic [CODE_W-1:0]    code_reg, code_next;

    always_comb
    begin
        valid_next   = valid_reg;
        alarm_next   = alarm_reg;
        timeout_next = timeout_reg;
        residue_next = residue_reg;
        code_next    = code_reg;
        if (shift_en)
        begin
            valid_next   = shift_in.valid;
            alarm_next   = shift_in.alarm;
            timeout_next = shift_in.timeout;
            residue_next = shift_in.residue;
            code_next    = shift_in.code;
        end
        else if (sel && cmd.create)
        begin
            valid_next   = 1'b1;
            alarm_next   = 1'b0;
            timeout_next = cmd.timeout;
            residue_next = cmd.timeout;
            code_next    = cmd.code;
        end
        else if (sel && cmd.feed && valid_reg)
        begin
            residue_next = timeout_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            alarm_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            alarm_reg <= alarm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        timeout_reg <= timeout_next;
        residue_reg <= residue_next;
        code_reg    <= code_next;
    end

    assign slot_q = '{valid: valid_reg, alarm: alarm_reg, timeout: timeout_reg,
                      residue: residue_reg, code: code_reg};

endmodule

// File: rtl/core/swdg_age.sv
// Aging unit at the head of the chain: residue compare and subtract, alarm
// code decode. Depends on swdg_pkg.
module swdg_age import swdg_pkg::*;
(
    input  slot_t                slot_in,
    input  logic [STEP_W-1:0]    tick_step,
    input  logic                 sound_enable,
    output slot_t                slot_out,
    output logic                 hit,
    output logic [COLOUR_W-1:0]  colour,
    output logic [BEEPS_W-1:0]   beeps
);

    logic [TIMEOUT_W-1:0] step_ext;
    logic [3:0]           hi_nib;
    logic [3:0]           lo_nib;
    logic                 known;

    assign step_ext = TIMEOUT_W'(tick_step);

    always_comb
    begin
        slot_out = slot_in;
        if (slot_in.valid)
        begin
            if (slot_in.residue < step_ext)
            begin
                slot_out.alarm = 1'b1;
            end
            else
            begin
                slot_out.alarm   = 1'b0;
                slot_out.residue = slot_in.residue - step_ext;
            end
        end
    end

    assign hit    = slot_out.valid & slot_out.alarm;
    assign hi_nib = slot_in.code[7:4];
    assign lo_nib = slot_in.code[3:0];
    assign known  = (hi_nib >= COLOUR_FIRST) && (hi_nib <= COLOUR_LAST) &&
                    (lo_nib >= BEEPS_FIRST) && (lo_nib <= BEEPS_LAST);
    assign colour = (sound_enable && known) ? hi_nib[COLOUR_W-1:0] : '0;
    assign beeps  = (sound_enable && known) ? lo_nib[BEEPS_W-1:0] : '0;

endmodule

// File: rtl/core/multi_channel_soft_watchdog.sv
// Multi-channel soft watchdog: slot table as a rotating chain of cells.
// Create and feed requests complete when taken; their result is on the port in the next cycle.
// A tick scans every slot as it passes the aging unit, then enters the flush state; it
// is held longer only while the result port stalls, and the next request is taken
// once the block is back in the idle state. A suspend result leaves staging
// when the next alarmed slot is found or in the flush state. Reset clears all slot
// valid and alarm flags and sets tick_step to 10.
module multi_channel_soft_watchdog import swdg_pkg::*;
#(
    parameter int CHANNELS = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    swdg_req_if.sink          req,
    swdg_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [STEP_W-1:0] cfg_data
);

    // Width of the scan counter; it also numbers the slot at the chain head.
    localparam int IW = $clog2(CHANNELS + 1);
    localparam logic [IW-1:0] IDX_LAST = IW'(CHANNELS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                sound_reg, sound_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [3:0]          found_reg, found_next;

    // Staging holds the latest suspend result until we know whether another
    // one follows, which decides its last flag.
    logic                stage_valid_reg, stage_valid_next;
    logic [CH_W-1:0]     stage_slot_reg, stage_slot_next;
    logic [COLOUR_W-1:0] stage_colour_reg, stage_colour_next;
    logic [BEEPS_W-1:0]  stage_beeps_reg, stage_beeps_next;

    logic                out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]   out_kind_reg, out_kind_next;
    logic [CH_W-1:0]     out_slot_reg, out_slot_next;
    logic [COLOUR_W-1:0] out_colour_reg, out_colour_next;
    logic [BEEPS_W-1:0]  out_beeps_reg, out_beeps_next;
    logic                out_last_reg, out_last_next;

    slot_t               cell_q [CHANNELS];
    slot_t               aged;
    logic                age_hit;
    logic [COLOUR_W-1:0] age_colour;
    logic [BEEPS_W-1:0]  age_beeps;

    cell_cmd_t           cmd;
    logic [CHANNELS-1:0] sel;
    logic [CHANNELS-1:0] valid_vec;
    logic                in_range;
    logic                feed_ok;
    logic                accept;
    logic                out_free;
    logic                hit_eff;
    logic                advance;
    logic                shift_en;
    logic [6:0]          idx_ext;

    // A new request is taken only between ticks and only when the output
    // register can take whatever the request produces in the same cycle.
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign cmd.create  = accept && (req.opcode == OP_CREATE);
    assign cmd.feed    = accept && (req.opcode == OP_FEED);
    assign cmd.timeout = req.timeout;
    assign cmd.code    = req.alarm_code;

    // The chain rotates toward cell 0; the head slot passes through the aging
    // unit and re-enters at the tail, so after CHANNELS shifts every slot is
    // back in its own cell.
    genvar gi;
    generate
        for (gi = 0; gi < CHANNELS; gi++)
        begin : g_cell
            slot_t shift_in;
            assign sel[gi]       = (7'(req.channel) == 7'(gi));
            assign valid_vec[gi] = cell_q[gi].valid;
            if (gi == CHANNELS - 1)
            begin : g_tail
                assign shift_in = aged;
            end
            else
            begin : g_body
                assign shift_in = cell_q[gi + 1];
            end
            swdg_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .sel      (sel[gi]),
                .shift_en (shift_en),
                .shift_in (shift_in),
                .slot_q   (cell_q[gi])
            );
        end
    endgenerate

    assign in_range = |sel;
    assign feed_ok  = |(sel & valid_vec);

    swdg_age u_age (
        .slot_in      (cell_q[0]),
        .tick_step    (step_reg),
        .sound_enable (sound_reg),
        .slot_out     (aged),
        .hit          (age_hit),
        .colour       (age_colour),
        .beeps        (age_beeps)
    );

    // Once SLOT_LIMIT results are found the remaining slots still age, but
    // they report nothing.
    assign hit_eff  = age_hit && (found_reg < 4'(SLOT_LIMIT));
    // The rotation pauses only when a new result meets a full staging
    // register whose content cannot move on to the output.
    assign advance  = !(hit_eff && stage_valid_reg && !out_free);
    assign shift_en = (state_reg == ST_SCAN) && advance;
    assign idx_ext  = 7'(idx_reg);

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        sound_next        = sound_reg;
        idx_next          = idx_reg;
        found_next        = found_reg;
        stage_valid_next  = stage_valid_reg;
        stage_slot_next   = stage_slot_reg;
        stage_colour_next = stage_colour_reg;
        stage_beeps_next  = stage_beeps_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_kind_next     = out_kind_reg;
        out_slot_next     = out_slot_reg;
        out_colour_next   = out_colour_reg;
        out_beeps_next    = out_beeps_reg;
        out_last_next     = out_last_reg;

        if (cfg_we)
        begin
            step_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.opcode)
                        OP_TICK:
                        begin
                            state_next = ST_SCAN;
                            sound_next = req.sound_enable;
                            idx_next   = '0;
                            found_next = '0;
                        end
                        OP_CREATE:
                        begin
                            if (in_range)
                            begin
                                out_valid_next  = 1'b1;
                                out_kind_next   = KIND_CREATE;
                                out_slot_next   = req.channel;
                                out_colour_next = '0;
                                out_beeps_next  = '0;
                                out_last_next   = 1'b1;
                            end
                        end
                        OP_FEED:
                        begin
                            if (feed_ok)
                            begin
                                out_valid_next  = 1'b1;
                                out_kind_next   = KIND_RESUME;
                                out_slot_next   = req.channel;
                                out_colour_next = '0;
                                out_beeps_next  = '0;
                                out_last_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            // Unused opcode: dropped without a result.
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (advance)
                begin
                    if (hit_eff)
                    begin
                        if (stage_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = KIND_SUSPEND;
                            out_slot_next   = stage_slot_reg;
                            out_colour_next = stage_colour_reg;
                            out_beeps_next  = stage_beeps_reg;
                            out_last_next   = 1'b0;
                        end
                        stage_valid_next  = 1'b1;
                        stage_slot_next   = idx_ext[CH_W-1:0];
                        stage_colour_next = age_colour;
                        stage_beeps_next  = age_beeps;
                        found_next        = found_reg + 4'd1;
                    end
                    if (idx_reg == IDX_LAST)
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!stage_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_kind_next    = KIND_SUSPEND;
                    out_slot_next    = stage_slot_reg;
                    out_colour_next  = stage_colour_reg;
                    out_beeps_next   = stage_beeps_reg;
                    out_last_next    = 1'b1;
                    stage_valid_next = 1'b0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= STEP_RESET;
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            found_reg       <= '0;
            idx_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            found_reg       <= found_next;
            idx_reg         <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sound_reg        <= sound_next;
        stage_slot_reg   <= stage_slot_next;
        stage_colour_reg <= stage_colour_next;
        stage_beeps_reg  <= stage_beeps_next;
        out_kind_reg     <= out_kind_next;
        out_slot_reg     <= out_slot_next;
        out_colour_reg   <= out_colour_next;
        out_beeps_reg    <= out_beeps_next;
        out_last_reg     <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.kind   = out_kind_reg;
    assign rsp.slot   = out_slot_reg;
    assign rsp.colour = out_colour_reg;
    assign rsp.beeps  = out_beeps_reg;
    assign rsp.last   = out_last_reg;

    // No request is taken while a tick is still rotating or flushing.
    a_busy_no_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request ready during a tick");

    // The per-tick result count never passes its limit.
    a_found_limit: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg <= 4'(SLOT_LIMIT))
        else $error("suspend count above limit");

    // A staged result exists only inside a tick.
    a_stage_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> (state_reg != ST_IDLE))
        else $error("staged result outside a tick");

    // The final slot of a rotation always leads to the flush state.
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && advance && idx_reg == IDX_LAST) |=>
        (state_reg == ST_FLUSH))
        else $error("rotation did not end in flush");

    // The flushed result is the last one of its tick.
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH && stage_valid_reg && out_free) |=>
        (rsp.valid && rsp.last && rsp.kind == KIND_SUSPEND))
        else $error("flushed result without last flag");

endmodule

// File: test/tb_multi_channel_soft_watchdog.sv
// Self-checking testbench for the multi-channel soft watchdog: directed table, then random phases.
// Depends on swdg_pkg and the request/result interfaces in swdg_if.sv.
// Uses an internal model of the slot table to predict every result.
module tb_multi_channel_soft_watchdog import swdg_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS         = 8;
    // The opcode value that the block must ignore.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    // A tick walks CHANNELS slots and then the flush state; this is a comfortable margin.
    localparam int DRAIN_CYCLES     = 20;
    // Cycles with no handshake on either channel before the run is declared hung.
    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PER_PHASE = 41;
    localparam int PHASES           = 7;

    // Alarm codes that decode to a real light colour and beep pattern.
    localparam logic [CODE_W-1:0] KNOWN_CODES [8] = '{
        8'h11, 8'h21, 8'h31, 8'h41, 8'h51, 8'h61, 8'h12, 8'h62
    };

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic [CH_W-1:0]      channel;
        logic [TIMEOUT_W-1:0] timeout;
        logic [CODE_W-1:0]    code;
        logic                 sound;
    } request_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [CH_W-1:0]     slot;
        logic [COLOUR_W-1:0] colour;
        logic [BEEPS_W-1:0]  beeps;
        logic                last;
    } result_t;

    // One row of the directed table. When "typed" is set the expected outcome is
    // written here by hand: either nothing, or one result of the given kind for
    // the addressed channel with colour and beeps at zero.
    typedef struct packed {
        request_t          req;
        logic              typed;
        logic              one;
        logic [KIND_W-1:0] kind;
    } row_t;

    localparam int PLAN_LEN = 23;
    localparam row_t PLAN [PLAN_LEN] = '{
        // Tick straight after reset: no slot is valid, so nothing comes back.
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b1}, 1'b1, 1'b0, KIND_CREATE},
        // Feed of a slot that was never created is ignored.
        '{'{OP_FEED,   3'd3, 24'd0,        8'h00, 1'b0}, 1'b1, 1'b0, KIND_CREATE},
        // The unused opcode is ignored.
        '{'{OP_UNUSED, 3'd0, 24'd0,        8'h00, 1'b0}, 1'b1, 1'b0, KIND_CREATE},
        // Arm every slot, with timeouts at, below and above the default step.
        '{'{OP_CREATE, 3'd0, 24'd0,        8'h11, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd7, 24'hFFFFFF,   8'h62, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd1, 24'd5,        8'h21, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd2, 24'd10,       8'h31, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd3, 24'd9,        8'h41, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd4, 24'd20,       8'h51, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd5, 24'd0,        8'h61, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd6, 24'd0,        8'h12, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        // Ticks with sound on and off.
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b1}, 1'b0, 1'b0, KIND_CREATE},
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b0}, 1'b0, 1'b0, KIND_CREATE},
        '{'{OP_FEED,   3'd0, 24'd0,        8'h00, 1'b0}, 1'b1, 1'b1, KIND_RESUME},
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b1}, 1'b0, 1'b0, KIND_CREATE},
        // Re-arm valid slots, with codes that decode to nothing.
        '{'{OP_CREATE, 3'd5, 24'd100,      8'h00, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd6, 24'd0,        8'h73, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_CREATE, 3'd3, 24'd0,        8'h1F, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b1}, 1'b0, 1'b0, KIND_CREATE},
        // Feed of an alarmed slot leaves the alarm for the next tick to decide.
        '{'{OP_FEED,   3'd1, 24'd0,        8'h00, 1'b0}, 1'b1, 1'b1, KIND_RESUME},
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b1}, 1'b0, 1'b0, KIND_CREATE},
        '{'{OP_CREATE, 3'd2, 24'd0,        8'hFF, 1'b0}, 1'b1, 1'b1, KIND_CREATE},
        '{'{OP_TICK,   3'd0, 24'd0,        8'h00, 1'b1}, 1'b0, 1'b0, KIND_CREATE}
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_data;

    swdg_req_if req_ch ();
    swdg_rsp_if rsp_ch ();

    multi_channel_soft_watchdog #(
        .CHANNELS (CHANNELS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the slot table and the tick step, kept in step with every
    // accepted request and every register write.
    logic [STEP_W-1:0]    step_now;
    logic                 slot_on      [CHANNELS];
    logic                 slot_alarmed [CHANNELS];
    logic [TIMEOUT_W-1:0] slot_reload  [CHANNELS];
    logic [TIMEOUT_W-1:0] slot_left    [CHANNELS];
    logic [CODE_W-1:0]    slot_pattern [CHANNELS];

    // Results still owed by the block, oldest first.
    result_t due_results [$];

    int mismatches  = 0;
    int idle_cycles = 0;
    // Set for the final phase, in which neither side idles.
    bit quiet = 1'b0;

    // Applies one accepted request to the shadow table and, when asked, queues
    // the results it causes. A tick first ages every valid slot, then reports
    // the alarmed ones in ascending slot order.
    function automatic void apply_request(input request_t r, input bit record);
        result_t    made [$];
        result_t    one;
        logic [3:0] hi;
        logic [3:0] lo;
        case (r.opcode)
            OP_TICK:
            begin
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (slot_on[i])
                    begin
                        if (slot_left[i] < TIMEOUT_W'(step_now))
                        begin
                            slot_alarmed[i] = 1'b1;
                        end
                        else
                        begin
                            slot_alarmed[i] = 1'b0;
                            slot_left[i]    = slot_left[i] - TIMEOUT_W'(step_now);
                        end
                    end
                end
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (slot_on[i] && slot_alarmed[i] && made.size() < SLOT_LIMIT)
                    begin
                        one      = '0;
                        one.kind = KIND_SUSPEND;
                        one.slot = i[CH_W-1:0];
                        hi       = slot_pattern[i][7:4];
                        lo       = slot_pattern[i][3:0];
                        // Colour and beeps only decode with sound on and a known code.
                        if (r.sound && hi >= COLOUR_FIRST && hi <= COLOUR_LAST &&
                            lo >= BEEPS_FIRST && lo <= BEEPS_LAST)
                        begin
                            one.colour = hi[COLOUR_W-1:0];
                            one.beeps  = lo[BEEPS_W-1:0];
                        end
                        made.push_back(one);
                    end
                end
            end
            OP_CREATE:
            begin
                if (int'(r.channel) < CHANNELS)
                begin
                    slot_on[r.channel]      = 1'b1;
                    slot_reload[r.channel]  = r.timeout;
                    slot_left[r.channel]    = r.timeout;
                    slot_pattern[r.channel] = r.code;
                    slot_alarmed[r.channel] = 1'b0;
                    one      = '0;
                    one.kind = KIND_CREATE;
                    one.slot = r.channel;
                    made.push_back(one);
                end
            end
            OP_FEED:
            begin
                if (int'(r.channel) < CHANNELS && slot_on[r.channel])
                begin
                    slot_left[r.channel] = slot_reload[r.channel];
                    one      = '0;
                    one.kind = KIND_RESUME;
                    one.slot = r.channel;
                    made.push_back(one);
                end
            end
            default:
            begin
            end
        endcase
        foreach (made[k])
        begin
            one      = made[k];
            one.last = (k == made.size() - 1);
            if (record)
            begin
                due_results.push_back(one);
            end
        end
    endfunction

    // Presents one request and holds it until the block takes it. Directed rows
    // with a hand-written outcome queue that outcome instead of the model's,
    // but the model still sees the request so its table stays current.
    task automatic send_request(input request_t r, input bit typed, input bit one,
                                input logic [KIND_W-1:0] kind);
        result_t hand;
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= r.opcode;
        req_ch.channel      <= r.channel;
        req_ch.timeout      <= r.timeout;
        req_ch.alarm_code   <= r.code;
        req_ch.sound_enable <= r.sound;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        apply_request(r, !typed);
        if (typed && one)
        begin
            hand      = '0;
            hand.kind = kind;
            hand.slot = r.channel;
            hand.last = 1'b1;
            due_results.push_back(hand);
        end
        // Random gaps between requests, so that a gap lands on every phase of
        // the block's work.
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    // The step register may only change while the block is idle: wait for all
    // owed results, then let any result-free tick finish before the write.
    task automatic write_step(input logic [STEP_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        step_now = value;
    endtask

    // Result side: ready comes in random high and low bursts, with some long
    // high stretches, and stays high once the final phase begins.
    initial
    begin : result_ready
        int burst;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            burst = quiet ? 16 : $urandom_range(1, 13);
            if ($urandom_range(0, 4) == 0)
            begin
                burst = 40;
            end
            rsp_ch.ready <= 1'b1;
            repeat (burst) @(posedge clk);
            if (!quiet && $urandom_range(0, 1) == 1)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
        end
    end

    // Every accepted result is compared with the oldest one owed.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_results.size() == 0)
            begin
                $error("result with none owed: kind %0d slot %0d", rsp_ch.kind, rsp_ch.slot);
                mismatches++;
            end
            else
            begin
                want = due_results.pop_front();
                if (rsp_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, actual %0d", want.kind, rsp_ch.kind);
                    mismatches++;
                end
                if (rsp_ch.slot !== want.slot)
                begin
                    $error("slot: expected %0d, actual %0d", want.slot, rsp_ch.slot);
                    mismatches++;
                end
                if (rsp_ch.colour !== want.colour)
                begin
                    $error("colour: expected %0d, actual %0d", want.colour, rsp_ch.colour);
                    mismatches++;
                end
                if (rsp_ch.beeps !== want.beeps)
                begin
                    $error("beeps: expected %0d, actual %0d", want.beeps, rsp_ch.beeps);
                    mismatches++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // Hang detector: any handshake on either channel restarts the count.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("multi_channel_soft_watchdog regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        request_t          r;
        logic [STEP_W-1:0] s;
        int                pick;
        int                span;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_data            = '0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = OP_TICK;
        req_ch.channel      = '0;
        req_ch.timeout      = '0;
        req_ch.alarm_code   = '0;
        req_ch.sound_enable = 1'b0;

        step_now = STEP_RESET;
        for (int i = 0; i < CHANNELS; i++)
        begin
            slot_on[i]      = 1'b0;
            slot_alarmed[i] = 1'b0;
            slot_reload[i]  = '0;
            slot_left[i]    = '0;
            slot_pattern[i] = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run at the reset value of the step.
        for (int k = 0; k < PLAN_LEN; k++)
        begin
            send_request(PLAN[k].req, PLAN[k].typed, PLAN[k].one, PLAN[k].kind);
        end

        // Random phases, each with its own tick step: the smallest, the largest,
        // zero (nothing ever alarms), arbitrary values and the reset value.
        // Every phase boundary also makes the sender wait until the block has
        // delivered every owed result.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       s = 16'd1;
                1:       s = 16'hFFFF;
                2:       s = 16'd0;
                3:       s = STEP_W'($urandom_range(1, 65535));
                4:       s = STEP_W'($urandom_range(2, 50));
                5:       s = STEP_RESET;
                default: s = STEP_W'($urandom_range(1, 40));
            endcase
            write_step(s);
            if (p == PHASES - 1)
            begin
                quiet = 1'b1;
            end
            repeat (RANDOM_PER_PHASE)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    r.opcode = OP_TICK;
                end
                else if (pick < 62)
                begin
                    r.opcode = OP_CREATE;
                end
                else if (pick < 95)
                begin
                    r.opcode = OP_FEED;
                end
                else
                begin
                    r.opcode = OP_UNUSED;
                end
                r.channel = CH_W'($urandom_range(0, CHANNELS - 1));
                r.sound   = 1'($urandom_range(0, 1));
                // Timeouts mostly sit within a few steps, so slots age into alarm
                // after a handful of ticks; the rest span the whole field.
                span = int'(step_now) * 4 + 4;
                case ($urandom_range(0, 9))
                    0:       r.timeout = '0;
                    1:       r.timeout = '1;
                    2, 3:    r.timeout = TIMEOUT_W'($urandom);
                    4, 5:    r.timeout = TIMEOUT_W'($urandom_range(0, int'(step_now)));
                    default: r.timeout = TIMEOUT_W'($urandom_range(0, span));
                endcase
                if ($urandom_range(0, 3) == 0)
                begin
                    r.code = CODE_W'($urandom);
                end
                else
                begin
                    r.code = KNOWN_CODES[$urandom_range(0, 7)];
                end
                send_request(r, 1'b0, 1'b0, KIND_CREATE);
            end
        end

        // Let the block deliver everything still owed, then a little more to
        // catch any stray result.
        req_ch.valid <= 1'b0;
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("multi_channel_soft_watchdog regression: pass");
        end
        else
        begin
            $display("multi_channel_soft_watchdog regression: fail");
        end
        $finish;
    end

endmodule
